>>> src/obtb_pkg.sv
// Shared types and codes for the order book top-of-book block.
// Used by obtb_front, obtb_back and order_book_top_of_book_core.
package obtb_pkg;

  // Operation codes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Side codes
  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  // Status codes
  localparam logic [1:0] STAT_DONE        = 2'd0;
  localparam logic [1:0] STAT_LEVEL_FULL  = 2'd1;
  localparam logic [1:0] STAT_QUEUE_FULL  = 2'd2;

  // One request as it travels from front to back
  typedef struct packed {
    logic        operation;
    logic        side;
    logic [31:0] price;
    logic [31:0] quantity;
    logic [31:0] user;
    logic [31:0] user_order;
  } obtb_req_t;

  // Best level of one side and the oldest entry there
  typedef struct packed {
    logic        valid;
    logic [31:0] price;
    logic [31:0] quantity;
    logic [31:0] user;
    logic [31:0] user_order;
  } obtb_top_t;

  // Handoff from front queue to back engine
  typedef struct packed {
    logic      valid;
    obtb_req_t req;
  } obtb_fe_t;

endpackage

>>> src/obtb_front.sv
// Front end: accepts requests and holds them in a two-entry queue.
// Depends on obtb_pkg.
module obtb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  obtb_pkg::obtb_req_t in_req,
  output obtb_pkg::obtb_fe_t  fe_out,
  input  logic              fe_pop
);
  import obtb_pkg::*;

  obtb_req_t  slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_stall     = (cnt_r == 2'd2);
  assign push         = in_valid && !in_stall;
  assign fe_out.valid = (cnt_r != 2'd0);
  assign fe_out.req   = slot_r[rd_ptr_r];

  // Hold payload of queued requests
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_req;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (fe_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, fe_pop};
    end
  end

endmodule

>>> src/obtb_back.sv
// Back end: level table search, level creation, best level tracking, result register.
// Depends on obtb_pkg.
module obtb_back #(
  parameter int LEVELS      = 16,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  obtb_pkg::obtb_fe_t fe_in,
  output logic               fe_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output obtb_pkg::obtb_top_t out_bid,
  output obtb_pkg::obtb_top_t out_ask
);
  import obtb_pkg::*;

  localparam int CW = $clog2(LEVELS + 1);
  localparam int AW = (2 * LEVELS > 1) ? $clog2(2 * LEVELS) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t      state_r;
  obtb_req_t   req_r;
  logic [CW-1:0] k_r;
  logic [CW-1:0] cnt_r [2];
  obtb_top_t   top_r [2];
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  obtb_top_t   out_bid_r;
  obtb_top_t   out_ask_r;

  // Level memory: price and fill count, side-major
  logic [31:0]   price_mem [2*LEVELS];
  logic [FW-1:0] fill_mem  [2*LEVELS];
  logic [31:0]   rd_price_r;
  logic [FW-1:0] rd_fill_r;

  obtb_req_t     cur;
  logic          out_free;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_price;
  logic [FW-1:0] wr_fill;
  logic          finish;
  logic [1:0]    fin_status;
  logic          go_scan;
  logic [CW-1:0] k_nxt;
  logic          create;
  logic          cnt_clr;
  logic          better;
  obtb_top_t     top_nxt [2];
  logic [CW-1:0] k_inc;

  function automatic logic [AW-1:0] lvl_addr(input logic sd, input logic [CW-1:0] slot);
    logic [AW-1:0] base;
    base = sd ? AW'(LEVELS) : '0;
    return base + AW'(slot);
  endfunction

  assign out_free = !out_valid_r || !out_stall;
  assign cur      = (state_r == S_IDLE) ? fe_in.req : req_r;
  assign k_inc    = k_r + CW'(1);

  // Decide the next step of the current request
  always_comb begin
    fe_pop     = 1'b0;
    rd_addr    = lvl_addr(cur.side, k_inc);
    we         = 1'b0;
    wr_addr    = lvl_addr(cur.side, cnt_r[cur.side]);
    wr_price   = cur.price;
    wr_fill    = FW'(1);
    finish     = 1'b0;
    fin_status = STAT_DONE;
    go_scan    = 1'b0;
    k_nxt      = k_r;
    create     = 1'b0;
    cnt_clr    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (fe_in.valid && out_free) begin
          fe_pop = 1'b1;
          if (cur.operation == OP_FLUSH) begin
            cnt_clr = 1'b1;
            finish  = 1'b1;
          end else if (cnt_r[cur.side] == '0) begin
            create = 1'b1;
          end else begin
            go_scan = 1'b1;
            k_nxt   = '0;
            rd_addr = lvl_addr(cur.side, '0);
          end
        end
      end
      S_SCAN: begin
        if (rd_price_r == cur.price) begin
          finish = 1'b1;
          if (rd_fill_r == FW'(QUEUE_DEPTH)) begin
            fin_status = STAT_QUEUE_FULL;
          end else begin
            we      = 1'b1;
            wr_addr = lvl_addr(cur.side, k_r);
            wr_fill = rd_fill_r + FW'(1);
          end
        end else if (k_inc == cnt_r[cur.side]) begin
          create = 1'b1;
        end else begin
          go_scan = 1'b1;
          k_nxt   = k_inc;
        end
      end
      default: ;
    endcase
    // Open a new level at the next free slot, or reject when the table is full
    if (create) begin
      finish = 1'b1;
      if (cnt_r[cur.side] == CW'(LEVELS)) begin
        fin_status = STAT_LEVEL_FULL;
        create     = 1'b0;
      end else begin
        we = 1'b1;
      end
    end
  end

  // Track the best level of each side
  always_comb begin
    top_nxt[0] = top_r[0];
    top_nxt[1] = top_r[1];
    better = (cur.side == SIDE_BUY) ? (cur.price > top_r[cur.side].price)
                                    : (cur.price < top_r[cur.side].price);
    if (cnt_clr) begin
      top_nxt[0].valid = 1'b0;
      top_nxt[1].valid = 1'b0;
    end else if (create && (!top_r[cur.side].valid || better)) begin
      top_nxt[cur.side] = '{valid: 1'b1, price: cur.price, quantity: cur.quantity,
                            user: cur.user, user_order: cur.user_order};
    end
  end

  // Write and read the level memory
  always_ff @(posedge clk) begin
    if (we) begin
      price_mem[wr_addr] <= wr_price;
      fill_mem[wr_addr]  <= wr_fill;
    end
    rd_price_r <= price_mem[rd_addr];
    rd_fill_r  <= fill_mem[rd_addr];
  end

  // Hold state, book counters and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      cnt_r[0]    <= '0;
      cnt_r[1]    <= '0;
      top_r[0]    <= '0;
      top_r[1]    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fe_pop) begin
        req_r <= fe_in.req;
      end
      k_r        <= k_nxt;
      top_r[0]   <= top_nxt[0];
      top_r[1]   <= top_nxt[1];
      if (cnt_clr) begin
        cnt_r[0] <= '0;
        cnt_r[1] <= '0;
      end else if (create) begin
        cnt_r[cur.side] <= cnt_r[cur.side] + CW'(1);
      end
      if (go_scan) begin
        state_r <= S_SCAN;
      end else if (finish) begin
        state_r <= S_IDLE;
      end
      if (finish) begin
        out_valid_r  <= 1'b1;
        out_status_r <= fin_status;
        if (top_nxt[0].valid && top_nxt[1].valid) begin
          out_bid_r <= top_nxt[0];
          out_ask_r <= top_nxt[1];
        end else begin
          out_bid_r <= '0;
          out_ask_r <= '0;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_bid    = out_bid_r;
  assign out_ask    = out_ask_r;

endmodule

>>> src/order_book_top_of_book_core.sv
// Channel   Ports                         Direction
// input     in_valid / in_stall, fields   request in
// result    out_valid / out_stall, fields request out
//
// A flush, or an add to a side holding no levels, finishes in the back end without a scan.
// An add to a side holding levels scans the level memory one slot per cycle through
// its single read port, until the price matches or the last slot is read.
// The front queue holds two requests; the result register frees when taken.
// Reset (rst_n low, synchronous) empties both sides and the queue.
// Top-level wrapper: depends on obtb_pkg, obtb_front and obtb_back.
module order_book_top_of_book_core #(
  parameter int LEVELS      = 16,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic        in_side,
  input  logic [31:0] in_price,
  input  logic [31:0] in_quantity,
  input  logic [31:0] in_user,
  input  logic [31:0] in_user_order,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_top_valid,
  output logic [31:0] out_bid_price,
  output logic [31:0] out_bid_quantity,
  output logic [31:0] out_bid_user,
  output logic [31:0] out_bid_user_order,
  output logic [31:0] out_ask_price,
  output logic [31:0] out_ask_quantity,
  output logic [31:0] out_ask_user,
  output logic [31:0] out_ask_user_order
);
  import obtb_pkg::*;

  obtb_req_t in_req;
  obtb_fe_t  fe;
  logic      fe_pop;
  obtb_top_t bid;
  obtb_top_t ask;

  assign in_req = '{operation: in_operation, side: in_side, price: in_price,
                    quantity: in_quantity, user: in_user, user_order: in_user_order};

  obtb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .fe_out   (fe),
    .fe_pop   (fe_pop)
  );

  obtb_back #(
    .LEVELS      (LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fe_in      (fe),
    .fe_pop     (fe_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_bid    (bid),
    .out_ask    (ask)
  );

  assign out_top_valid      = bid.valid && ask.valid;
  assign out_bid_price      = bid.price;
  assign out_bid_quantity   = bid.quantity;
  assign out_bid_user       = bid.user;
  assign out_bid_user_order = bid.user_order;
  assign out_ask_price      = ask.price;
  assign out_ask_quantity   = ask.quantity;
  assign out_ask_user       = ask.user;
  assign out_ask_user_order = ask.user_order;

  // Pop only from a non-empty front queue
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fe_pop |-> fe.valid) else $error("pop from empty front queue");

  // When either book side is empty, both sides report zero prices
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_top_valid) |-> (out_bid_price == 32'd0 && out_ask_price == 32'd0))
    else $error("top fields not cleared");

  // Queue is not full (no stall) right after reset
  a_reset_open: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !in_stall) else $error("stall after reset");

endmodule
